@@ rtl/adjacent_layer_mutual_pair_merge_unit_defines.svh @@
// Assertion macros for the adjacent-layer pair merge unit.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef ADJACENT_LAYER_MUTUAL_PAIR_MERGE_UNIT_DEFINES_SVH
`define ADJACENT_LAYER_MUTUAL_PAIR_MERGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ALMPM_ASSERT_IMP(lbl, pre, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (con)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ALMPM_ASSERT_NXT(lbl, pre, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (con)) \
        else $error(msg);

`endif

@@ rtl/almpm_pkg.sv @@
// Shared types, constants and helper functions of the pair merge unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package almpm_pkg;

    localparam int MAX_CLUSTERS_DEF = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int LAYER_W  = 6;
    localparam int POS_W    = 15;
    localparam int PHI_W    = 16;
    localparam int EN_W     = 20;
    localparam int ESUM_W   = 21;
    localparam int PAIRS_W  = 6;

    localparam logic [PHI_W-1:0] LIMIT_RESET = 16'd31;
    localparam logic [PHI_W-1:0] PHI_HALF    = 16'h8000;

    // Coordinate select codes for the divider
    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_Z = 2'd2;

    typedef struct packed {
        logic [LAYER_W-1:0]      layer;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [PHI_W-1:0]        phi;
        logic [EN_W-1:0]         energy;
    } item_t;

    // Cluster record held in a cell, shifted along the chain for readout
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic [LAYER_W-1:0]      layer;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [PHI_W-1:0]        phi;
        logic [EN_W-1:0]         energy;
        logic [IDX_W-1:0]        best;
        logic                    bvalid;
        logic                    mutual;
        logic signed [POS_W-1:0] qx;
        logic signed [POS_W-1:0] qy;
        logic signed [POS_W-1:0] qz;
        logic [EN_W-1:0]         qe;
    } rec_t;

    // Visiting copy that circulates round the ring
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic [LAYER_W-1:0]      layer;
        logic [PHI_W-1:0]        phi;
        logic [IDX_W-1:0]        best;
        logic                    bvalid;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [EN_W-1:0]         energy;
    } vis_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic               load_en;
        logic [IDX_W-1:0]   load_idx;
        item_t              item;
        logic               init_search;
        logic               search;
        logic               init_match;
        logic               match;
        logic               shift;
        logic [CNT_W-1:0]   n;
        logic [PHI_W-1:0]   limit;
    } ctl_t;

    // Wrapped azimuth distance in binary angle units
    function automatic logic [PHI_W-1:0] phi_dist(input logic [PHI_W-1:0] a,
                                                  input logic [PHI_W-1:0] b);
        logic [PHI_W-1:0] d;
        d = a - b;
        return (d > PHI_HALF) ? (~d + 16'd1) : d;
    endfunction

    // Layers differ by exactly one (no wrap at the top layer)
    function automatic logic adjacent(input logic [LAYER_W-1:0] la,
                                      input logic [LAYER_W-1:0] lb);
        logic [LAYER_W:0] a;
        logic [LAYER_W:0] b;
        a = {1'b0, la};
        b = {1'b0, lb};
        return (a + 7'd1 == b) || (b + 7'd1 == a);
    endfunction

endpackage

@@ rtl/adjacent_layer_mutual_pair_merge_unit.sv @@
// Channel  | dir | tdata (low bit up)                            | tuser  | tlast
// s_       | in  | layer, pos_x, pos_y, pos_z, phi, energy, pad  | -      | last
// m_       | out | out_x, out_y, out_z, energy_sum, pair_count   | paired | last_result
// cfg_wr_  | in  | max_phi_dist                                  | -      | -
//
// Loading accepts one cluster per cycle. After the last cluster the cell chain runs
// a search ring and a match ring, then rotates the records once to count pairs. A
// solo result goes straight to the output register; a pair centroid goes through
// the bit-serial divider for x, y and z in turn, then through the hand-off and
// emit states.
// Reset is synchronous, active low; cluster stores need no clearing.
// A stalled m_ side holds the readout; s_tready is high only while loading.
`timescale 1ns / 1ps
`include "adjacent_layer_mutual_pair_merge_unit_defines.svh"

module adjacent_layer_mutual_pair_merge_unit #(
    parameter int MAX_CLUSTERS = almpm_pkg::MAX_CLUSTERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: max_phi_dist
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // s_tdata: layer[5:0], pos_x[20:6], pos_y[35:21], pos_z[50:36],
    //          phi[66:51], energy[86:67], zero pad [87]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tlast,
    // m_tdata: out_x[14:0], out_y[29:15], out_z[44:30], energy_sum[65:45],
    //          pair_count[71:66]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    // m_tuser: paired
    output logic        m_tuser,
    output logic        m_tlast
);
    import almpm_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLUSTERS);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_INIT_S = 9'b000000010,
        S_SEARCH = 9'b000000100,
        S_INIT_M = 9'b000001000,
        S_MATCH  = 9'b000010000,
        S_COUNT  = 9'b000100000,
        S_EMIT   = 9'b001000000,
        S_DIVIDE = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        step_reg;
    logic [PAIRS_W-1:0]      pairs_reg;
    logic [1:0]              coord_reg;
    logic                    go_reg;
    logic [PHI_W-1:0]        limit_reg;
    logic signed [POS_W-1:0] cx_reg;
    logic signed [POS_W-1:0] cy_reg;
    logic signed [POS_W-1:0] cz_reg;

    logic                    m_valid_reg;
    logic signed [POS_W-1:0] m_x_reg;
    logic signed [POS_W-1:0] m_y_reg;
    logic signed [POS_W-1:0] m_z_reg;
    logic [ESUM_W-1:0]       m_esum_reg;
    logic [PAIRS_W-1:0]      m_pairs_reg;
    logic                    m_paired_reg;
    logic                    m_last_reg;

    ctl_t                    ctl;
    rec_t                    rec_out [MAX_CLUSTERS];
    vis_t                    vis_out [MAX_CLUSTERS];
    rec_t                    rec_top_in;
    logic [MAX_CLUSTERS-1:0] emit_vec;

    rec_t                    head;
    logic                    head_skip;
    logic [ESUM_W-1:0]       head_esum;
    logic                    head_div;
    logic                    later;
    logic                    out_free;
    logic                    s_accept;
    logic                    out_load;
    logic                    div_start;
    logic                    div_done;
    logic signed [POS_W-1:0] div_q;
    logic signed [POS_W-1:0] div_pa;
    logic signed [POS_W-1:0] div_pb;

    // head of the chain and readout decisions
    assign head      = rec_out[0];
    assign head_skip = head.mutual && head.best < head.idx;
    assign head_esum = {1'b0, head.energy} + {1'b0, head.qe};
    assign head_div  = head.mutual && head_esum != '0;
    assign later     = |emit_vec[MAX_CLUSTERS-1:1];
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = state_reg == S_IDLE;
    assign s_accept  = s_tvalid && s_tready;

    assign out_load  = (state_reg == S_EMIT && head.valid && !head_skip && !head_div && out_free)
                       || (state_reg == S_OUT && out_free);

    // control broadcast to the cells
    always_comb begin
        ctl.load_en     = s_accept && cnt_reg < CNT_MAX;
        ctl.load_idx    = cnt_reg[IDX_W-1:0];
        ctl.item.layer  = s_tdata[5:0];
        ctl.item.px     = s_tdata[20:6];
        ctl.item.py     = s_tdata[35:21];
        ctl.item.pz     = s_tdata[50:36];
        ctl.item.phi    = s_tdata[66:51];
        ctl.item.energy = s_tdata[86:67];
        ctl.init_search = state_reg == S_INIT_S;
        ctl.search      = state_reg == S_SEARCH;
        ctl.init_match  = state_reg == S_INIT_M;
        ctl.match       = state_reg == S_MATCH;
        ctl.shift       = (state_reg == S_COUNT) || out_load
                          || (state_reg == S_EMIT && head.valid && head_skip);
        ctl.n           = cnt_reg;
        ctl.limit       = limit_reg;
    end

    // top cell refills from cell 0 while counting, with an empty record otherwise
    assign rec_top_in = (state_reg == S_COUNT) ? rec_out[0] : '0;

    // chain of cells: records move towards cell 0, visitors go round the ring
    for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
        almpm_cell #(
            .CELL_IDX(k)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .rec_in  ((k == MAX_CLUSTERS - 1) ? rec_top_in : rec_out[(k + 1) % MAX_CLUSTERS]),
            .rec_out (rec_out[k]),
            .vis_in  (vis_out[(k + MAX_CLUSTERS - 1) % MAX_CLUSTERS]),
            .vis_out (vis_out[k])
        );
        assign emit_vec[k] = rec_out[k].valid
                             && !(rec_out[k].mutual && rec_out[k].best < rec_out[k].idx);
    end

    // divider operand select
    always_comb begin
        case (coord_reg)
            COORD_X: begin
                div_pa = head.px;
                div_pb = head.qx;
            end
            COORD_Y: begin
                div_pa = head.py;
                div_pb = head.qy;
            end
            default: begin
                div_pa = head.pz;
                div_pb = head.qz;
            end
        endcase
    end

    assign div_start = state_reg == S_DIVIDE && go_reg;

    almpm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pa      (div_pa),
        .ea      (head.energy),
        .pb      (div_pb),
        .eb      (head.qe),
        .done    (div_done),
        .quot    (div_q)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            pairs_reg <= '0;
            coord_reg <= COORD_X;
            go_reg    <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (cnt_reg < CNT_MAX) begin
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                        if (s_tlast) begin
                            state_reg <= S_INIT_S;
                        end
                    end
                end
                S_INIT_S: begin
                    step_reg  <= '0;
                    state_reg <= S_SEARCH;
                end
                S_SEARCH: begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == CNT_MAX - 7'd1) begin
                        state_reg <= S_INIT_M;
                    end
                end
                S_INIT_M: begin
                    step_reg  <= '0;
                    pairs_reg <= '0;
                    state_reg <= S_MATCH;
                end
                S_MATCH: begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == CNT_MAX - 7'd1) begin
                        step_reg  <= '0;
                        state_reg <= S_COUNT;
                    end
                end
                // full rotation of the records, counting each pair at its lower index
                S_COUNT: begin
                    if (head.valid && head.mutual && head.idx < head.best) begin
                        pairs_reg <= pairs_reg + 6'd1;
                    end
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == CNT_MAX - 7'd1) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!head.valid) begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else if (!head_skip && head_div) begin
                        coord_reg <= COORD_X;
                        go_reg    <= 1'b1;
                        state_reg <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    if (div_start) begin
                        go_reg <= 1'b0;
                    end
                    if (div_done) begin
                        case (coord_reg)
                            COORD_X: begin
                                cx_reg    <= div_q;
                                coord_reg <= COORD_Y;
                                go_reg    <= 1'b1;
                            end
                            COORD_Y: begin
                                cy_reg    <= div_q;
                                coord_reg <= COORD_Z;
                                go_reg    <= 1'b1;
                            end
                            default: begin
                                cz_reg    <= div_q;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_EMIT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pairs_reg  <= pairs_reg;
            m_last_reg   <= !later;
            m_paired_reg <= head.mutual;
            if (state_reg == S_OUT) begin
                m_x_reg    <= cx_reg;
                m_y_reg    <= cy_reg;
                m_z_reg    <= cz_reg;
                m_esum_reg <= head_esum;
            end else begin
                m_x_reg    <= head.px;
                m_y_reg    <= head.py;
                m_z_reg    <= head.pz;
                m_esum_reg <= head.mutual ? '0 : {1'b0, head.energy};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pairs_reg, m_esum_reg, m_z_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_paired_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `ALMPM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_MAX, "load count beyond capacity")
    `ALMPM_ASSERT_IMP(a_div_owned, div_done, state_reg == S_DIVIDE, "divider done outside divide")
    `ALMPM_ASSERT_IMP(a_pairs_bound, 1'b1, (CNT_W'(pairs_reg) << 1) <= CNT_MAX, "too many pairs")
    `ALMPM_ASSERT_NXT(a_out_loaded, out_load, m_valid_reg, "result not presented after load")

endmodule

@@ rtl/almpm_cell.sv @@
// One cell of the cluster chain: holds a record, searches its partner.
// Depends on almpm_pkg.
`timescale 1ns / 1ps

module almpm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              aclk,
    input  almpm_pkg::ctl_t   ctl,
    input  almpm_pkg::rec_t   rec_in,
    output almpm_pkg::rec_t   rec_out,
    input  almpm_pkg::vis_t   vis_in,
    output almpm_pkg::vis_t   vis_out
);
    import almpm_pkg::*;

    rec_t             rec_reg;
    vis_t             vis_reg;
    logic [PHI_W-1:0] bestd_reg;

    logic             own_valid;
    logic [PHI_W-1:0] d;
    logic             better;
    logic             hit;
    vis_t             own_vis;

    assign own_valid = ctl.n > CNT_W'(CELL_IDX);
    assign d         = phi_dist(rec_reg.phi, vis_reg.phi);

    // candidate check: strictly closer, or equally close at a lower index
    always_comb begin
        better = vis_reg.valid && rec_reg.valid && adjacent(rec_reg.layer, vis_reg.layer)
                 && ((d < bestd_reg)
                     || (rec_reg.bvalid && d == bestd_reg && vis_reg.idx < rec_reg.best));
        hit    = vis_reg.valid && rec_reg.bvalid && vis_reg.bvalid
                 && vis_reg.idx == rec_reg.best && vis_reg.best == rec_reg.idx;
    end

    // copy of the own record that goes out on the ring
    always_comb begin
        own_vis.valid  = ctl.init_search ? own_valid : rec_reg.valid;
        own_vis.idx    = rec_reg.idx;
        own_vis.layer  = rec_reg.layer;
        own_vis.phi    = rec_reg.phi;
        own_vis.best   = rec_reg.best;
        own_vis.bvalid = ctl.init_search ? 1'b0 : rec_reg.bvalid;
        own_vis.px     = rec_reg.px;
        own_vis.py     = rec_reg.py;
        own_vis.pz     = rec_reg.pz;
        own_vis.energy = rec_reg.energy;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_en && ctl.load_idx == IDX_W'(CELL_IDX)) begin
            rec_reg.idx    <= IDX_W'(CELL_IDX);
            rec_reg.layer  <= ctl.item.layer;
            rec_reg.px     <= ctl.item.px;
            rec_reg.py     <= ctl.item.py;
            rec_reg.pz     <= ctl.item.pz;
            rec_reg.phi    <= ctl.item.phi;
            rec_reg.energy <= ctl.item.energy;
        end else if (ctl.shift) begin
            rec_reg <= rec_in;
        end else if (ctl.init_search) begin
            rec_reg.valid  <= own_valid;
            rec_reg.bvalid <= 1'b0;
            rec_reg.best   <= '0;
            bestd_reg      <= ctl.limit;
            vis_reg        <= own_vis;
        end else if (ctl.search) begin
            if (better) begin
                bestd_reg      <= d;
                rec_reg.best   <= vis_reg.idx;
                rec_reg.bvalid <= 1'b1;
            end
            vis_reg <= vis_in;
        end else if (ctl.init_match) begin
            rec_reg.mutual <= 1'b0;
            vis_reg        <= own_vis;
        end else if (ctl.match) begin
            if (hit) begin
                rec_reg.mutual <= 1'b1;
                rec_reg.qx     <= vis_reg.px;
                rec_reg.qy     <= vis_reg.py;
                rec_reg.qz     <= vis_reg.pz;
                rec_reg.qe     <= vis_reg.energy;
            end
            vis_reg <= vis_in;
        end
    end

    assign rec_out = rec_reg;
    assign vis_out = vis_reg;

endmodule

@@ rtl/almpm_div.sv @@
// Energy-weighted centroid of one coordinate, restoring division one bit a cycle.
// Depends on almpm_pkg.
`timescale 1ns / 1ps

module almpm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [almpm_pkg::POS_W-1:0] pa,
    input  logic [almpm_pkg::EN_W-1:0]     ea,
    input  logic signed [almpm_pkg::POS_W-1:0] pb,
    input  logic [almpm_pkg::EN_W-1:0]     eb,
    output logic                           done,
    output logic signed [almpm_pkg::POS_W-1:0] quot
);
    import almpm_pkg::*;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_PREP = 4'b0100,
        D_ITER = 4'b1000
    } dstate_t;

    dstate_t            st_reg;
    logic signed [35:0] prod_a_reg;
    logic signed [35:0] prod_b_reg;
    logic [ESUM_W-1:0]  den_reg;
    logic               neg_reg;
    logic [36:0]        rem_reg;
    logic [36:0]        dsh_reg;
    logic [POS_W-1:0]   q_reg;
    logic [3:0]         it_reg;
    logic               done_reg;

    logic signed [20:0] ea_s;
    logic signed [20:0] eb_s;
    logic signed [36:0] num;
    logic [35:0]        mag;

    assign ea_s = $signed({1'b0, ea});
    assign eb_s = $signed({1'b0, eb});
    assign num  = 37'(prod_a_reg) + 37'(prod_b_reg);
    assign mag  = num[36] ? 36'(-num) : 36'(num);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (st_reg)
                D_IDLE: begin
                    if (start) begin
                        prod_a_reg <= pa * ea_s;
                        prod_b_reg <= pb * eb_s;
                        den_reg    <= {1'b0, ea} + {1'b0, eb};
                        st_reg     <= D_MUL;
                    end
                end
                D_MUL: begin
                    st_reg <= D_PREP;
                end
                // round half away from zero: (2|n| + s) / (2s)
                D_PREP: begin
                    neg_reg <= num[36];
                    rem_reg <= {mag, 1'b0} + 37'(den_reg);
                    dsh_reg <= 37'({den_reg, 1'b0}) << (POS_W - 1);
                    it_reg  <= 4'(POS_W - 1);
                    st_reg  <= D_ITER;
                end
                D_ITER: begin
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg   <= {q_reg[POS_W-2:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[POS_W-2:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                    it_reg  <= it_reg - 4'd1;
                    if (it_reg == 4'd0) begin
                        done_reg <= 1'b1;
                        st_reg   <= D_IDLE;
                    end
                end
                default: st_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(-q_reg) : $signed(q_reg);

endmodule

@@ dv/tb_top.sv @@
// Testbench for the adjacent-layer mutual pair merge unit: random cluster events,
// self-checking against an in-bench pairing and centroid predictor.
// Depends on almpm_pkg and the unit's top level only.
`timescale 1ns / 1ps

// Scoreboard: holds the event being loaded and the queue of expected results
class pair_merge_scoreboard;
    typedef struct packed {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic signed [14:0] z;
        logic [20:0]        esum;
        logic               paired;
        logic [5:0]         pairs;
        logic               last;
    } merged_t;

    almpm_pkg::item_t held[64];
    int               held_cnt;
    logic [15:0]      phi_limit;
    merged_t          pending[$];
    int               errors;
    int               results_seen;
    int               events;

    function new();
        held_cnt = 0;
        phi_limit = 16'd31;
        errors = 0;
        results_seen = 0;
        events = 0;
    endfunction

    function logic [15:0] wrap_dist(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d > 16'h8000) ? 16'(17'h10000 - d) : d;
    endfunction

    // Rounded energy-weighted mean, ties away from zero
    function logic signed [14:0] centroid(longint pa, longint ea, longint pb, longint eb);
        longint num;
        longint mag;
        longint q;
        num = pa * ea + pb * eb;
        mag = num < 0 ? -num : num;
        q = (2 * mag + ea + eb) / (2 * (ea + eb));
        return 15'(num < 0 ? -q : q);
    endfunction

    // Note an accepted cluster; on the last one, work out the event's results
    function void note_cluster(almpm_pkg::item_t it, logic last);
        int   best[64];
        bit   has[64];
        int   lim;
        int   d;
        int   j;
        int   npairs;
        merged_t r;
        if (held_cnt < 64) begin
            held[held_cnt] = it;
            held_cnt++;
        end
        if (!last) return;
        events++;
        for (int i = 0; i < held_cnt; i++) begin
            lim = phi_limit;
            has[i] = 0;
            best[i] = 0;
            for (int k = 0; k < held_cnt; k++) begin
                if (int'(held[i].layer) + 1 != int'(held[k].layer) &&
                    int'(held[k].layer) + 1 != int'(held[i].layer)) continue;
                d = wrap_dist(held[i].phi, held[k].phi);
                if (d < lim) begin
                    lim = d;
                    best[i] = k;
                    has[i] = 1;
                end
            end
        end
        npairs = 0;
        for (int i = 0; i < held_cnt; i++) begin
            j = best[i];
            if (has[i] && has[j] && best[j] == i && i < j) npairs++;
        end
        for (int i = 0; i < held_cnt; i++) begin
            j = best[i];
            r.pairs = 6'(npairs);
            r.last = 0;
            if (has[i] && has[j] && best[j] == i) begin
                if (j < i) continue;
                r.esum = 21'(held[i].energy) + 21'(held[j].energy);
                r.paired = 1;
                if (r.esum == 0) begin
                    r.x = held[i].px;
                    r.y = held[i].py;
                    r.z = held[i].pz;
                end else begin
                    r.x = centroid(held[i].px, held[i].energy, held[j].px, held[j].energy);
                    r.y = centroid(held[i].py, held[i].energy, held[j].py, held[j].energy);
                    r.z = centroid(held[i].pz, held[i].energy, held[j].pz, held[j].energy);
                end
            end else begin
                r.x = held[i].px;
                r.y = held[i].py;
                r.z = held[i].pz;
                r.esum = 21'(held[i].energy);
                r.paired = 0;
            end
            pending = {pending, r};
        end
        if (held_cnt > 0) pending[pending.size() - 1].last = 1;
        held_cnt = 0;
    endfunction

    // Compare one output transaction against the oldest expectation
    function void check_result(logic [71:0] data, logic paired, logic last);
        merged_t e;
        results_seen++;
        if (pending.size() == 0) begin
            $error("unexpected result transaction data=%h", data);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (data[14:0] !== e.x) begin
            $error("out_x exp %0d got %0d", e.x, $signed(data[14:0])); errors++;
        end
        if (data[29:15] !== e.y) begin
            $error("out_y exp %0d got %0d", e.y, $signed(data[29:15])); errors++;
        end
        if (data[44:30] !== e.z) begin
            $error("out_z exp %0d got %0d", e.z, $signed(data[44:30])); errors++;
        end
        if (data[65:45] !== e.esum) begin
            $error("energy_sum exp %0d got %0d", e.esum, data[65:45]); errors++;
        end
        if (data[71:66] !== e.pairs) begin
            $error("pair_count exp %0d got %0d", e.pairs, data[71:66]); errors++;
        end
        if (paired !== e.paired) begin
            $error("paired exp %0d got %0d", e.paired, paired); errors++;
        end
        if (last !== e.last) begin
            $error("last_result exp %0d got %0d", e.last, last); errors++;
        end
    endfunction
endclass

module tb_top;
    import almpm_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    pair_merge_scoreboard sb;
    int   cycles = 0;
    int   clusters_sent;
    int   burst_left;
    logic gaps_on;
    int   stall_mode = 0;

    adjacent_layer_mutual_pair_merge_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stall pattern and output check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (cycles % 7) < 2;
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
        if ($urandom_range(0, 400) == 0) stall_mode <= $urandom_range(0, 3);
    end

    function automatic logic [87:0] pack_cluster(item_t it);
        return {1'b0, it.energy, it.phi, it.pz, it.py, it.px, it.layer};
    endfunction

    // Send one cluster, waiting for acceptance; bursts with random gaps.
    // tvalid stays high after acceptance until a gap or the end of a sequence.
    task automatic send_cluster(item_t it, logic last);
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pack_cluster(it);
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tready === 1'b1));
        sb.note_cluster(it, last);
        clusters_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_limit(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.phi_limit = v;
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic item_t rand_cluster(int base_layer, logic [15:0] base_phi, int spread);
        item_t it;
        it.layer  = 6'(base_layer + $urandom_range(0, 2));
        it.px     = 15'($urandom);
        it.py     = 15'($urandom);
        it.pz     = 15'($urandom);
        it.phi    = base_phi + 16'($urandom_range(0, spread)) - 16'(spread / 2);
        it.energy = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 3)) : 20'($urandom);
        return it;
    endfunction

    // One event of n clusters clustered around a phi so pairs actually form
    task automatic send_event(int n, int spread);
        int          bl;
        logic [15:0] bp;
        bl = $urandom_range(0, 61);
        bp = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) bl = $urandom_range(0, 61);
            send_cluster(rand_cluster(bl, bp, spread), i == n - 1);
        end
    endtask

    initial begin
        item_t it;
        sb = new();
        aresetn = 1'b0;
        clusters_sent = 0;
        burst_left = 0;
        gaps_on = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single cluster at the field extremes, at reset limit
        it = '{layer: 6'd63, px: 15'h3fff, py: 15'h4000, pz: 15'h3fff,
               phi: 16'hffff, energy: 20'hfffff};
        send_cluster(it, 1'b1);
        wait_drained();
        // Pair across phi wrap, extreme energies and positions
        it = '{layer: 6'd0, px: 15'h4000, py: 15'h3fff, pz: 15'h0,
               phi: 16'hfffe, energy: 20'hfffff};
        send_cluster(it, 1'b0);
        it = '{layer: 6'd1, px: 15'h3fff, py: 15'h4000, pz: 15'h7fff,
               phi: 16'h0003, energy: 20'hfffff};
        send_cluster(it, 1'b1);
        wait_drained();
        // Zero energy clusters, plus a same-layer non-partner and a tie in phi distance
        it = '{layer: 6'd10, px: 15'd100, py: -15'sd5, pz: 15'd7, phi: 16'd1000, energy: 20'd0};
        send_cluster(it, 1'b0);
        it = '{layer: 6'd11, px: 15'd300, py: 15'd5, pz: 15'd9, phi: 16'd1002, energy: 20'd0};
        send_cluster(it, 1'b0);
        it = '{layer: 6'd9, px: 15'd1, py: 15'd2, pz: 15'd3, phi: 16'd998, energy: 20'd1};
        send_cluster(it, 1'b0);
        it = '{layer: 6'd10, px: 15'd4, py: 15'd5, pz: 15'd6, phi: 16'd1001, energy: 20'd3};
        send_cluster(it, 1'b1);
        wait_drained();
        // Limit at its extremes
        write_limit(16'h8000);
        send_event(6, 65535);
        wait_drained();
        write_limit(16'd0);
        send_event(5, 4);
        wait_drained();
        // Full store plus dropped clusters, the last dropped one starting the search
        write_limit(16'd200);
        send_event(66, 600);
        wait_drained();

        // Random phase: several limit settings, bursty sender
        gaps_on = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_limit(16'd31);
                1: write_limit(16'd1);
                2: write_limit(16'(  $urandom_range(20, 3000)));
                default: write_limit(16'hffff);
            endcase
            while (clusters_sent < 60 + 40 * (ph + 1))
                send_event($urandom_range(1, 12), $urandom_range(2, 400));
            wait_drained();
        end

        $display("Covered %0d clusters in %0d events, %0d results checked.",
                 clusters_sent, sb.events, sb.results_seen);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
